// ===== rtl/otsu_threshold_binarizer_macros.svh =====
// Assertion macros shared by the Otsu binarizer RTL.
`ifndef OTSU_THRESHOLD_BINARIZER_MACROS_SVH
`define OTSU_THRESHOLD_BINARIZER_MACROS_SVH

// Implication checked outside reset.
`define OTB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked on every edge, reset included.
`define OTB_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/otb_pkg.sv =====
// Shared types and constants for the Otsu threshold binarizer.
package otb_pkg;

   localparam int MAX_PIXELS_LOG2 = 22;
   localparam int BINS            = 256;
   localparam int PIX_W           = 8;
   localparam int BIN_ADDR_W      = $clog2(BINS);
   localparam int CNT_W           = MAX_PIXELS_LOG2;
   localparam int TOT_W           = MAX_PIXELS_LOG2 + 1;
   localparam int SUM_W           = CNT_W + PIX_W;
   localparam int PROD_W          = TOT_W + SUM_W;
   localparam int NUM_W           = 2 * PROD_W;
   localparam int DEN_W           = 2 * TOT_W;
   localparam int MUL_B_W         = PROD_W;
   localparam int ACC_W           = NUM_W + MUL_B_W;
   localparam int MUL_CNT_W       = $clog2(MUL_B_W);
   localparam int THR_W           = 9;

   localparam logic [TOT_W-1:0] CNT_CAP = TOT_W'((64'd1 << MAX_PIXELS_LOG2) - 64'd1);
   localparam logic [PIX_W-1:0] T_FIRST = 8'd1;
   localparam logic [PIX_W-1:0] T_LAST  = 8'd254;
   localparam logic [PIX_W-1:0] PIX_HI  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_LO  = 8'd0;
   localparam logic signed [THR_W-1:0] THR_NONE = -9'sd1;

   typedef enum logic [1:0] {
      OP_COUNT,
      OP_COUNT_LAST,
      OP_BINARIZE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [PIX_W-1:0] pixel;
   } q_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIST_UPD,
      ST_SRCH_RD,
      ST_SRCH_ACC,
      ST_SRCH_P,
      ST_SRCH_Q,
      ST_SRCH_DEN,
      ST_MUL_NUM,
      ST_MUL_LHS,
      ST_MUL_RHS,
      ST_SRCH_NEXT,
      ST_EMIT
   } back_state_type;

endpackage

// ===== rtl/otsu_threshold_binarizer.sv =====
// Otsu threshold binarizer: 8-bit gray histogram, threshold search, pixel binarization.
//
// Input channel req_*: one pixel per transaction. req_tuser = 0 counts the pixel into
// the histogram; with req_tlast set, the threshold search runs after counting it.
// req_tuser = 1 binarizes the pixel against the stored threshold (0 at or above, else 255).
// Result channel rsp_*: rsp_tuser = 1 carries a threshold (-1 when none), 0 a binary pixel.
// A two-entry queue separates intake from the back end, and one output register holds
// a result while the receiver stalls; a stall backs up into req_tready only once both fill.
// Binarize transactions run at one per cycle while the back end is idle and the output
// register is free; a histogram transaction is a memory read, then a write in the back end.
// The search walks 254 candidates; each takes up to three shift-add multiplications, and
// during the search no further transaction is taken beyond the queue.
// Reset (synchronous) empties the queue and histogram and sets the stored threshold to 0.
module otsu_threshold_binarizer
   import otb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic [0:0]  req_tuser,   // [0] kind
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [8:0] threshold, [16:9] binary_pixel, [23:17] zero
   output logic [0:0]  rsp_tuser    // [0] is_threshold
);

`include "otsu_threshold_binarizer_macros.svh"

   logic                    q_valid;
   q_item_type              q_item;
   logic                    q_pop;
   logic                    rsp_is_thr;
   logic signed [THR_W-1:0] rsp_thr;
   logic [PIX_W-1:0]        rsp_bin;
   back_state_type          back_state;

   otb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   otb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_is_thr (rsp_is_thr),
      .rsp_thr    (rsp_thr),
      .rsp_bin    (rsp_bin),
      .state      (back_state)
   );

   assign rsp_tdata = {7'd0, rsp_bin, rsp_thr};
   assign rsp_tuser = rsp_is_thr;

   `OTB_ASSERT_ALWAYS(a_rst_no_rsp, clock, $past(reset), !rsp_tvalid, "result valid right after reset")
   `OTB_ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, q_valid && back_state == ST_IDLE, "queue popped outside idle")
   `OTB_ASSERT_IMPL(a_bin_fields, clock, reset, rsp_tvalid && !rsp_is_thr, rsp_thr == '0 && (rsp_bin == PIX_LO || rsp_bin == PIX_HI), "bad binarize result")
   `OTB_ASSERT_IMPL(a_thr_fields, clock, reset, rsp_tvalid && rsp_is_thr, rsp_bin == '0 && rsp_thr != 9'sd255 && (rsp_thr >= 0 || rsp_thr == THR_NONE), "bad threshold result")

endmodule

// ===== rtl/otb_front.sv =====
// Front end: accepts pixel transactions, classifies them and queues them for the back end.
module otb_front
   import otb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [0:0]       req_tuser,
   input  logic             req_tlast,
   output logic             q_valid,
   output q_item_type       q_item,
   input  logic             q_pop
);

   localparam int DEPTH = 2;

   q_item_type       slot_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   q_item_type       new_item;

   assign req_tready = (count_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.pixel = req_tdata;
      if (req_tuser[0]) begin
         new_item.op = OP_BINARIZE;
      end else if (req_tlast) begin
         new_item.op = OP_COUNT_LAST;
      end else begin
         new_item.op = OP_COUNT;
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/otb_sermul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
module otb_sermul
   import otb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic               done,
   output logic [ACC_W-1:0]   product
);

   logic [ACC_W-1:0]     a_ff, a_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   assign done    = done_ff;
   assign product = acc_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = ACC_W'(op_a);
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== rtl/otb_back.sv =====
// Back end: histogram memory, threshold search sequencer and result register.
module otb_back
   import otb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  q_item_type              q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_thr,
   output logic signed [THR_W-1:0] rsp_thr,
   output logic [PIX_W-1:0]        rsp_bin,
   output back_state_type          state
);

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]      mem [BINS];
   logic [BINS-1:0]       vld_ff;
   logic [CNT_W-1:0]      rd_ff;
   logic                  rdv_ff;
   logic [BIN_ADDR_W-1:0] rd_addr;
   logic                  mem_we;
   logic                  vld_clr;

   logic [PIX_W-1:0]      pix_ff, pix_in;
   logic                  last_ff, last_in;
   logic [TOT_W-1:0]      n_ff, n_in;
   logic [SUM_W-1:0]      s_ff, s_in;
   logic [TOT_W-1:0]      nb_ff, nb_in;
   logic [SUM_W-1:0]      sb_ff, sb_in;
   logic [PROD_W-1:0]     p_ff, p_in;
   logic [PROD_W-1:0]     q_ff, q_in;
   logic [PROD_W-1:0]     d_ff, d_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [NUM_W-1:0]      bnum_ff, bnum_in;
   logic [DEN_W-1:0]      bden_ff, bden_in;
   logic [ACC_W-1:0]      lhs_ff, lhs_in;
   logic                  have_ff, have_in;
   logic [PIX_W-1:0]      t_ff, t_in;
   logic signed [THR_W-1:0] best_ff, best_in;
   logic signed [THR_W-1:0] thr_ff, thr_in;

   logic                    out_v_ff, out_v_in;
   logic                    out_thr_flag_ff, out_thr_flag_in;
   logic signed [THR_W-1:0] out_thr_ff, out_thr_in;
   logic [PIX_W-1:0]        out_bin_ff, out_bin_in;

   logic                  out_free;
   logic [CNT_W-1:0]      h;
   logic [TOT_W-1:0]      nf;
   logic [PIX_W-1:0]      tm1;
   logic                  mul_start;
   logic [NUM_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic                  mul_done;
   logic [ACC_W-1:0]      mul_prod;

   otb_sermul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign rsp_valid  = out_v_ff;
   assign rsp_is_thr = out_thr_flag_ff;
   assign rsp_thr    = out_thr_ff;
   assign rsp_bin    = out_bin_ff;
   assign state      = state_ff;
   assign out_free   = !out_v_ff || rsp_ready;
   assign h          = rdv_ff ? rd_ff : '0;
   assign nf         = n_ff - nb_ff;
   assign tm1        = t_ff - 1'b1;

   always_comb begin
      state_in        = state_ff;
      pix_in          = pix_ff;
      last_in         = last_ff;
      n_in            = n_ff;
      s_in            = s_ff;
      nb_in           = nb_ff;
      sb_in           = sb_ff;
      p_in            = p_ff;
      q_in            = q_ff;
      d_in            = d_ff;
      den_in          = den_ff;
      num_in          = num_ff;
      bnum_in         = bnum_ff;
      bden_in         = bden_ff;
      lhs_in          = lhs_ff;
      have_in         = have_ff;
      t_in            = t_ff;
      best_in         = best_ff;
      thr_in          = thr_ff;
      out_v_in        = out_v_ff && !rsp_ready;
      out_thr_flag_in = out_thr_flag_ff;
      out_thr_in      = out_thr_ff;
      out_bin_in      = out_bin_ff;
      q_pop           = 1'b0;
      mem_we          = 1'b0;
      vld_clr         = 1'b0;
      mul_start       = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      rd_addr         = (state_ff == ST_IDLE) ? q_item.pixel : tm1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_BINARIZE) begin
                  if (out_free) begin
                     q_pop           = 1'b1;
                     out_v_in        = 1'b1;
                     out_thr_flag_in = 1'b0;
                     out_thr_in      = '0;
                     out_bin_in      = ($signed({1'b0, q_item.pixel}) >= thr_ff) ? PIX_LO : PIX_HI;
                  end
               end else begin
                  q_pop    = 1'b1;
                  pix_in   = q_item.pixel;
                  last_in  = (q_item.op == OP_COUNT_LAST);
                  state_in = ST_HIST_UPD;
               end
            end
         end
         ST_HIST_UPD: begin
            if (n_ff < CNT_CAP) begin
               mem_we = 1'b1;
               n_in   = n_ff + 1'b1;
               s_in   = s_ff + SUM_W'(pix_ff);
            end
            if (last_ff) begin
               nb_in    = '0;
               sb_in    = '0;
               have_in  = 1'b0;
               best_in  = THR_NONE;
               t_in     = T_FIRST;
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_ACC;
         end
         ST_SRCH_ACC: begin
            nb_in    = nb_ff + TOT_W'(h);
            sb_in    = sb_ff + SUM_W'(tm1) * SUM_W'(h);
            state_in = ST_SRCH_P;
         end
         ST_SRCH_P: begin
            if (nb_ff == '0 || nf == '0) begin
               state_in = ST_SRCH_NEXT;
            end else begin
               p_in     = PROD_W'(n_ff) * PROD_W'(sb_ff);
               state_in = ST_SRCH_Q;
            end
         end
         ST_SRCH_Q: begin
            q_in     = PROD_W'(s_ff) * PROD_W'(nb_ff);
            state_in = ST_SRCH_DEN;
         end
         ST_SRCH_DEN: begin
            den_in    = DEN_W'(nb_ff) * DEN_W'(nf);
            d_in      = (p_ff >= q_ff) ? (p_ff - q_ff) : (q_ff - p_ff);
            mul_start = 1'b1;
            mul_a     = NUM_W'(d_in);
            mul_b     = d_in;
            state_in  = ST_MUL_NUM;
         end
         ST_MUL_NUM: begin
            if (mul_done) begin
               num_in = mul_prod[NUM_W-1:0];
               if (!have_ff) begin
                  have_in  = 1'b1;
                  bnum_in  = mul_prod[NUM_W-1:0];
                  bden_in  = den_ff;
                  best_in  = $signed({1'b0, t_ff});
                  state_in = ST_SRCH_NEXT;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = mul_prod[NUM_W-1:0];
                  mul_b     = MUL_B_W'(bden_ff);
                  state_in  = ST_MUL_LHS;
               end
            end
         end
         ST_MUL_LHS: begin
            if (mul_done) begin
               lhs_in    = mul_prod;
               mul_start = 1'b1;
               mul_a     = bnum_ff;
               mul_b     = MUL_B_W'(den_ff);
               state_in  = ST_MUL_RHS;
            end
         end
         ST_MUL_RHS: begin
            if (mul_done) begin
               // strictly better only, so ties keep the smaller threshold
               if (lhs_ff > mul_prod) begin
                  bnum_in = num_ff;
                  bden_in = den_ff;
                  best_in = $signed({1'b0, t_ff});
               end
               state_in = ST_SRCH_NEXT;
            end
         end
         ST_SRCH_NEXT: begin
            if (t_ff == T_LAST) begin
               state_in = ST_EMIT;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_v_in        = 1'b1;
               out_thr_flag_in = 1'b1;
               out_thr_in      = best_ff;
               out_bin_in      = '0;
               thr_in          = best_ff;
               vld_clr         = 1'b1;
               n_in            = '0;
               s_in            = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         n_ff     <= '0;
         s_ff     <= '0;
         thr_ff   <= '0;
         vld_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         n_ff     <= n_in;
         s_ff     <= s_in;
         thr_ff   <= thr_in;
         rdv_ff   <= vld_ff[rd_addr];
         if (vld_clr) begin
            vld_ff <= '0;
         end else if (mem_we) begin
            vld_ff[pix_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[pix_ff] <= h + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff          <= pix_in;
      last_ff         <= last_in;
      nb_ff           <= nb_in;
      sb_ff           <= sb_in;
      p_ff            <= p_in;
      q_ff            <= q_in;
      d_ff            <= d_in;
      den_ff          <= den_in;
      num_ff          <= num_in;
      bnum_ff         <= bnum_in;
      bden_ff         <= bden_in;
      lhs_ff          <= lhs_in;
      have_ff         <= have_in;
      t_ff            <= t_in;
      best_ff         <= best_in;
      out_thr_flag_ff <= out_thr_flag_in;
      out_thr_ff      <= out_thr_in;
      out_bin_ff      <= out_bin_in;
   end

endmodule

// ===== tb/otb_checker.sv =====
// Checker for the Otsu binarizer: predicts results from accepted pixels and compares them.
module otb_checker
   import otb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic [0:0]  req_tuser,   // [0] kind
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [8:0] threshold, [16:9] binary_pixel, [23:17] zero
   input  logic [0:0]  rsp_tuser,   // [0] is_threshold
   output int          err_count,
   output int          pending
);

   typedef struct packed {
      logic                     is_thr;
      logic signed [THR_W-1:0]  thr;
      logic [PIX_W-1:0]         bin;
   } otb_result_type;

   otb_result_type           result_q[$];
   logic [CNT_W-1:0]         hist[BINS];
   logic [TOT_W-1:0]         hist_total;
   logic signed [THR_W-1:0]  cur_thr;

   // Exact Otsu: maximize D*D/(nb*nf), D = N*Sb - S*nb; strict improvement keeps smallest t.
   function automatic logic signed [THR_W-1:0] otsu_search();
      logic [255:0]            n_all, s_all, nb, sb, nf, p, q, d, num, den, best_num, best_den;
      logic                    have;
      logic signed [THR_W-1:0] best_t;
      n_all = '0; s_all = '0; nb = '0; sb = '0;
      best_num = '0; best_den = '0; have = 1'b0; best_t = THR_NONE;
      for (int v = 0; v < BINS; v++) begin
         n_all += 256'(hist[v]);
         s_all += 256'(v) * 256'(hist[v]);
      end
      for (int t = 1; t < 255; t++) begin
         nb += 256'(hist[t-1]);
         sb += 256'(t - 1) * 256'(hist[t-1]);
         nf = n_all - nb;
         if (nb == 0 || nf == 0) continue;
         p = n_all * sb;
         q = s_all * nb;
         d = (p >= q) ? p - q : q - p;
         num = d * d;
         den = nb * nf;
         if (have && (num * best_den <= best_num * den)) continue;
         have = 1'b1;
         best_num = num;
         best_den = den;
         best_t = THR_W'(t);
      end
      return best_t;
   endfunction

   always @(posedge clock) begin
      otb_result_type got, want;
      if (reset) begin
         for (int i = 0; i < BINS; i++) hist[i] = '0;
         hist_total = '0;
         cur_thr = '0;
         result_q.delete();
         err_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_thr = rsp_tuser[0];
            got.thr    = rsp_tdata[8:0];
            got.bin    = rsp_tdata[16:9];
            if (result_q.size() == 0) begin
               $error("unexpected result transaction: is_threshold=%0d data=%h",
                      got.is_thr, rsp_tdata);
               err_count++;
            end else begin
               want = result_q[0];
               result_q.delete(0);
               if (got.is_thr !== want.is_thr) begin
                  $error("is_threshold: expected %0d, got %0d", want.is_thr, got.is_thr);
                  err_count++;
               end
               if (got.thr !== want.thr) begin
                  $error("threshold: expected %0d, got %0d", want.thr, got.thr);
                  err_count++;
               end
               if (got.bin !== want.bin) begin
                  $error("binary_pixel: expected %0d, got %0d", want.bin, got.bin);
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               want.is_thr = 1'b0;
               want.thr    = '0;
               want.bin    = ($signed({1'b0, req_tdata}) >= cur_thr) ? PIX_LO : PIX_HI;
               result_q.insert(result_q.size(), want);
            end else begin
               if (hist_total < CNT_CAP) begin
                  hist[req_tdata]++;
                  hist_total++;
               end
               if (req_tlast) begin
                  cur_thr = otsu_search();
                  for (int i = 0; i < BINS; i++) hist[i] = '0;
                  hist_total = '0;
                  want.is_thr = 1'b1;
                  want.thr    = cur_thr;
                  want.bin    = '0;
                  result_q.insert(result_q.size(), want);
               end
            end
         end
      end
      pending = result_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the Otsu binarizer: clock, reset, pixel stimulus, stalls and verdict.
module tb;
   import otb_pkg::*;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [7:0]  req_tdata;    // [7:0] pixel
   logic [0:0]  req_tuser;    // [0] kind
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;    // [8:0] threshold, [16:9] binary_pixel, [23:17] zero
   logic [0:0]  rsp_tuser;    // [0] is_threshold
   int          err_count, pending;
   int          send_idle_pct, recv_idle_pct, pixels_sent;
   bit          hold_req;

   otsu_threshold_binarizer DUT (.*);
   otb_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb: errors");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off when requested
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 300;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_pixel(input bit kind, input logic [7:0] pix, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pix;
      req_tuser  = kind;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      pixels_sent++;
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] near_level(int center, int spread);
      int v;
      v = center + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // one histogram image with random shape, ending on a pixel with last
   task automatic send_image();
      int n, shape, c0, c1;
      case ($urandom_range(19))
         0:       n = 1;
         1:       n = $urandom_range(200, 400);
         default: n = $urandom_range(3, 60);
      endcase
      shape = $urandom_range(4);
      c0 = $urandom_range(255);
      c1 = $urandom_range(255);
      for (int i = 0; i < n; i++) begin
         logic [7:0] pix;
         case (shape)
            0: pix = 8'($urandom_range(255));
            1: pix = c0[7:0];
            2: pix = $urandom_range(1) ? PIX_HI : PIX_LO;
            default: pix = $urandom_range(1) ? near_level(c0, 12) : near_level(c1, 20);
         endcase
         push_pixel(1'b0, pix, i == n - 1);
      end
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0; req_tlast = 1'b0;
      hold_req = 1'b0;
      send_idle_pct = 0; recv_idle_pct = 0; pixels_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // before any search the threshold is zero: everything binarizes to 0
      push_pixel(1'b1, PIX_LO, 1'b1);
      push_pixel(1'b1, PIX_HI, 1'b0);
      // single pixel: no split possible, threshold -1
      push_pixel(1'b0, 8'd128, 1'b1);
      push_pixel(1'b1, PIX_LO, 1'b0);
      // levels 0 and 255 only: threshold 1
      push_pixel(1'b0, PIX_LO, 1'b0);
      push_pixel(1'b0, PIX_HI, 1'b1);
      push_pixel(1'b1, PIX_LO, 1'b0);
      push_pixel(1'b1, 8'd1, 1'b0);
      push_pixel(1'b1, PIX_HI, 1'b1);
      // only levels 254 and 255: background never nonempty, -1
      push_pixel(1'b0, PIX_HI, 1'b0);
      push_pixel(1'b0, PIX_HI, 1'b0);
      push_pixel(1'b0, T_LAST, 1'b1);
      push_pixel(1'b1, 8'd77, 1'b0);
      // levels 0,0,1: threshold 1
      push_pixel(1'b0, PIX_LO, 1'b0);
      push_pixel(1'b0, PIX_LO, 1'b0);
      push_pixel(1'b0, T_FIRST, 1'b1);
      push_pixel(1'b1, PIX_LO, 1'b0);
      push_pixel(1'b1, T_FIRST, 1'b0);
      // two clusters
      push_pixel(1'b0, 8'd10, 1'b0);
      push_pixel(1'b0, 8'd12, 1'b0);
      push_pixel(1'b0, 8'd200, 1'b0);
      push_pixel(1'b0, 8'd210, 1'b1);
      push_pixel(1'b1, 8'd100, 1'b0);
      push_pixel(1'b1, 8'd205, 1'b0);

      phase = -1;
      while (pixels_sent < 1900) begin
         if (pixels_sent * 3 / 1900 != phase) begin
            phase = pixels_sent * 3 / 1900;
            wait_drained();
            case (phase)
               0: begin send_idle_pct = 27; recv_idle_pct = 79; end
               1: begin send_idle_pct = 79; recv_idle_pct = 27; end
               default: begin
                  send_idle_pct = 0; recv_idle_pct = 0;
                  // long receiver hold-off while pixels keep coming
                  hold_req = 1'b1;
                  repeat (40)
                     push_pixel(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
               end
            endcase
         end
         // stretches without idling inside the stalled phases
         if (phase < 2 && $urandom_range(9) == 0) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (phase == 0) begin
            send_idle_pct = 27; recv_idle_pct = 79;
         end else if (phase == 1) begin
            send_idle_pct = 79; recv_idle_pct = 27;
         end
         send_image();
         repeat ($urandom_range(20, 80))
            push_pixel(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end

      wait_drained();
      repeat (60) @(negedge clock);
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/otb_pkg.sv
rtl/otb_front.sv
rtl/otb_sermul.sv
rtl/otb_back.sv
rtl/otsu_threshold_binarizer.sv
tb/otb_checker.sv
tb/tb.sv
